// ===== src/sha1_message_digest_top_defines.svh =====
// Assertion macros for the RTL top level.
`ifndef SHA1_MESSAGE_DIGEST_TOP_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define SHA1MD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sha1md assertion failed");
`define SHA1MD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sha1md assertion failed");
`else
`define SHA1MD_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SHA1MD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== src/sha1md_pkg.sv =====
package sha1md_pkg;

    localparam int BLOCK_WORDS  = 16;
    localparam int ROUNDS       = 80;
    localparam int DIGEST_WORDS = 5;
    localparam int CNT_W        = $clog2(BLOCK_WORDS + 1);
    localparam int RND_W        = $clog2(ROUNDS);
    localparam int IDX_W        = 3;

    localparam logic [31:0] SHA1_IV [DIGEST_WORDS] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
    };

    localparam logic [31:0] K_CH   = 32'h5A82_7999;
    localparam logic [31:0] K_PAR1 = 32'h6ED9_EBA1;
    localparam logic [31:0] K_MAJ  = 32'h8F1B_BCDC;
    localparam logic [31:0] K_PAR2 = 32'hCA62_C1D6;

    localparam logic [31:0] PAD_BYTE_MSB = 32'h8000_0000;

    typedef logic [1:0] t_phase;
    localparam t_phase PH_CH   = 2'd0;
    localparam t_phase PH_PAR1 = 2'd1;
    localparam t_phase PH_MAJ  = 2'd2;
    localparam t_phase PH_PAR2 = 2'd3;

    typedef struct packed {
        logic             absorb;
        logic             push_pad;
        logic             push_zero;
        logic             push_hi;
        logic             push_lo;
        logic             round;
        t_phase           phase;
        logic             add;
        logic             init;
        logic [IDX_W-1:0] out_idx;
    } t_cmd;

    typedef struct packed {
        logic blk_full;
        logic cnt14;
        logic fill_next;
    } t_status;

    function automatic logic [31:0] round_k(input t_phase ph);
        logic [31:0] k;
        unique case (ph)
            PH_CH:   k = K_CH;
            PH_PAR1: k = K_PAR1;
            PH_MAJ:  k = K_MAJ;
            default: k = K_PAR2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] round_f(input t_phase ph, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        unique case (ph)
            PH_CH:   f = (b & c) | (~b & d);
            PH_MAJ:  f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

// ===== src/sha1md_if.sv =====
interface sha1md_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        end_of_message;

    modport source (output valid, data_word, byte_count, end_of_message, input ready);
    modport sink   (input valid, data_word, byte_count, end_of_message, output ready);
endinterface

interface sha1md_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== src/sha1_message_digest_top.sv =====
// SHA-1 hasher. Message bytes come in as big-endian 32-bit beats on i_msg
// (first byte in bits 31:24, byte_count valid bytes, end_of_message on the
// final beat, which may carry zero to four bytes). Bytes are packed into
// 64-byte blocks; a full block takes 80 compression rounds, one per clock,
// plus a fold into the chaining value. Input is taken one beat per clock
// while a block fills, and held off during compression and the fold, so
// the rate at which a message runs is
// set by the single shared round unit. After the final beat the block pads
// (0x80, zero fill, 64-bit bit count) and compresses once or twice more,
// then sends the five digest words on o_dig, index 0 first, last_word on
// index 4, and restarts from the initial hash value for the next message.
// No input is taken between the final beat and delivery of the fifth word.
`include "sha1_message_digest_top_defines.svh"

module sha1_message_digest_top
    import sha1md_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    sha1md_in_if.sink    i_msg,
    sha1md_out_if.source o_dig
);

    t_cmd    cmd;
    t_status st;
    logic    in_ready;
    logic    out_valid;

    // sequencer: absorb, rounds, padding, digest readout
    sha1md_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_msg.valid),
        .i_in_eom    (i_msg.end_of_message),
        .i_out_ready (o_dig.ready),
        .i_st        (st),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // byte packer, schedule window, round logic, chaining value
    sha1md_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_word   (i_msg.data_word),
        .i_byte_count  (i_msg.byte_count),
        .o_st          (st),
        .o_digest_word (o_dig.digest_word)
    );

    assign i_msg.ready      = in_ready;
    assign o_dig.valid      = out_valid;
    assign o_dig.word_index = cmd.out_idx;
    assign o_dig.last_word  = (cmd.out_idx == IDX_W'(DIGEST_WORDS - 1));

    // input and output sides never open together
    `SHA1MD_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, in_ready, !out_valid)
    // a full block is always compressed before more input is taken
    `SHA1MD_ASSERT_IMPL(a_full_blocks_input, i_clk, i_rst_n, st.blk_full, !in_ready)
    // delivering the last digest word returns to taking input
    `SHA1MD_ASSERT_NEXT(a_back_to_idle, i_clk, i_rst_n, out_valid && o_dig.ready && o_dig.last_word, in_ready)
    // rounds and pushes are never commanded together
    `SHA1MD_ASSERT_IMPL(a_round_excl, i_clk, i_rst_n, cmd.round, !(cmd.absorb || cmd.push_pad || cmd.push_zero || cmd.push_hi || cmd.push_lo))

endmodule

// ===== src/sha1md_dp.sv =====
module sha1md_dp
    import sha1md_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    output t_status     o_st,
    output logic [31:0] o_digest_word
);

    logic [31:0]      r_h [DIGEST_WORDS];   // chaining value
    logic [31:0]      r_x [DIGEST_WORDS];   // working a..e
    logic [31:0]      r_w [BLOCK_WORDS];    // schedule window, r_w[0] is W(t)
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_acc;                // partial word, unused bytes zero
    logic [1:0]       r_nacc;
    logic [63:0]      r_len;

    logic [2:0]  c_bytes;
    logic [31:0] c_mask;
    logic [2:0]  c_total;
    logic [55:0] c_comb;
    logic        c_absorb_push;
    logic        c_push;
    logic [31:0] c_push_word;
    logic [31:0] c_sched;
    logic [31:0] c_t;

    assign c_bytes = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;

    always_comb begin
        case (c_bytes)
            3'd0:    c_mask = 32'h0000_0000;
            3'd1:    c_mask = 32'hFF00_0000;
            3'd2:    c_mask = 32'hFFFF_0000;
            3'd3:    c_mask = 32'hFFFF_FF00;
            default: c_mask = 32'hFFFF_FFFF;
        endcase
    end

    assign c_total = {1'b0, r_nacc} + c_bytes;
    assign c_comb  = {r_acc, 24'h0} | ({i_data_word & c_mask, 24'h0} >> {r_nacc, 3'b000});
    assign c_absorb_push = i_cmd.absorb && (c_total >= 3'd4);

    always_comb begin
        c_push      = 1'b1;
        c_push_word = 32'h0;
        if (c_absorb_push) begin
            c_push_word = c_comb[55:24];
        end else if (i_cmd.push_pad) begin
            c_push_word = r_acc | (PAD_BYTE_MSB >> {r_nacc, 3'b000});
        end else if (i_cmd.push_hi) begin
            c_push_word = r_len[63:32];
        end else if (i_cmd.push_lo) begin
            c_push_word = r_len[31:0];
        end else if (!i_cmd.push_zero) begin
            c_push = 1'b0;
        end
    end

    // W(t+16) = rol1(W(t+13) ^ W(t+8) ^ W(t+2) ^ W(t))
    always_comb begin
        logic [31:0] x;
        x       = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        c_sched = {x[30:0], x[31]};
    end

    assign c_t = {r_x[0][26:0], r_x[0][31:27]} + round_f(i_cmd.phase, r_x[1], r_x[2], r_x[3])
               + r_x[4] + round_k(i_cmd.phase) + r_w[0];

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) r_w[i] <= r_w[i+1];
            r_w[BLOCK_WORDS-1] <= c_push_word;
        end else if (i_cmd.round) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) r_w[i] <= r_w[i+1];
            r_w[BLOCK_WORDS-1] <= c_sched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                r_h[i] <= SHA1_IV[i];
                r_x[i] <= SHA1_IV[i];
            end
        end else if (i_cmd.add) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                r_h[i] <= r_h[i] + r_x[i];
                r_x[i] <= r_h[i] + r_x[i];
            end
        end else if (i_cmd.round) begin
            r_x[0] <= c_t;
            r_x[1] <= r_x[0];
            r_x[2] <= {r_x[1][1:0], r_x[1][31:2]};
            r_x[3] <= r_x[2];
            r_x[4] <= r_x[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            r_cnt  <= '0;
            r_acc  <= '0;
            r_nacc <= '0;
            r_len  <= '0;
        end else begin
            if (i_cmd.add) begin
                r_cnt <= '0;
            end else if (c_push) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.absorb) begin
                r_len <= r_len + {58'h0, c_bytes, 3'b000};
                if (c_total >= 3'd4) begin
                    r_acc  <= {c_comb[23:0], 8'h00};
                    r_nacc <= 2'(c_total - 3'd4);
                end else begin
                    r_acc  <= c_comb[55:24];
                    r_nacc <= c_total[1:0];
                end
            end else if (i_cmd.push_pad) begin
                r_acc  <= '0;
                r_nacc <= '0;
            end
        end
    end

    assign o_st.blk_full  = (r_cnt == CNT_W'(BLOCK_WORDS));
    assign o_st.cnt14     = (r_cnt == CNT_W'(BLOCK_WORDS - 2));
    assign o_st.fill_next = (r_cnt == CNT_W'(BLOCK_WORDS - 1)) && (c_total >= 3'd4);

    assign o_digest_word = r_h[i_cmd.out_idx];

endmodule

// ===== src/sha1md_ctrl.sv =====
module sha1md_ctrl
    import sha1md_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_eom,
    input  logic    i_out_ready,
    input  t_status i_st,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ROUND  = 3'd1;
    localparam logic [2:0] S_ADD    = 3'd2;
    localparam logic [2:0] S_PAD    = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_LEN_HI = 3'd5;
    localparam logic [2:0] S_LEN_LO = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [RND_W-1:0] r_rnd, n_rnd;
    logic             r_final, n_final;
    logic             r_padded, n_padded;
    logic             r_last_blk, n_last_blk;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_comb begin
        n_state    = r_state;
        n_rnd      = r_rnd;
        n_final    = r_final;
        n_padded   = r_padded;
        n_last_blk = r_last_blk;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_cmd.out_idx = r_idx;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;

        if (r_rnd < RND_W'(20))      o_cmd.phase = PH_CH;
        else if (r_rnd < RND_W'(40)) o_cmd.phase = PH_PAR1;
        else if (r_rnd < RND_W'(60)) o_cmd.phase = PH_MAJ;
        else                         o_cmd.phase = PH_PAR2;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.absorb = 1'b1;
                    n_final      = i_in_eom;
                    if (i_st.fill_next) begin
                        n_state = S_ROUND;
                        n_rnd   = '0;
                    end else if (i_in_eom) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (r_rnd == RND_W'(ROUNDS - 1)) begin
                    n_state = S_ADD;
                end else begin
                    n_rnd = r_rnd + 1'b1;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (r_last_blk) begin
                    n_state = S_OUT;
                    n_idx   = '0;
                end else if (r_final) begin
                    n_state = r_padded ? S_FILL : S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                o_cmd.push_pad = 1'b1;
                n_padded       = 1'b1;
                n_state        = S_FILL;
            end
            S_FILL: begin
                if (i_st.blk_full) begin
                    n_state = S_ROUND;
                    n_rnd   = '0;
                end else if (i_st.cnt14) begin
                    n_state = S_LEN_HI;
                end else begin
                    o_cmd.push_zero = 1'b1;
                end
            end
            S_LEN_HI: begin
                o_cmd.push_hi = 1'b1;
                n_state       = S_LEN_LO;
            end
            S_LEN_LO: begin
                o_cmd.push_lo = 1'b1;
                n_last_blk    = 1'b1;
                n_state       = S_FILL;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_idx == IDX_W'(DIGEST_WORDS - 1)) begin
                        o_cmd.init = 1'b1;
                        n_final    = 1'b0;
                        n_padded   = 1'b0;
                        n_last_blk = 1'b0;
                        n_state    = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rnd      <= '0;
            r_final    <= 1'b0;
            r_padded   <= 1'b0;
            r_last_blk <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_rnd      <= n_rnd;
            r_final    <= n_final;
            r_padded   <= n_padded;
            r_last_blk <= n_last_blk;
            r_idx      <= n_idx;
        end
    end

endmodule

// ===== verif/tb_top.sv =====
module tb_top
    import sha1md_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Roughly 500 message beats in total. The final stretch runs with no idling.
    localparam int BEAT_TARGET = 500;
    localparam int CALM_TAIL   = 60;
    // Enough cycles after the queue empties for any stray extra word to appear.
    localparam int DRAIN_CYCLES = 200;

    // One digest word the block should produce.
    typedef struct {
        logic [31:0]      word;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_digest_beat;

    // Scoreboard with a built-in SHA-1 engine. Each accepted input beat is
    // folded into a byte stream. An end-of-message beat queues the five
    // digest words that the block should send.
    class sha1_digest_board;
        logic [31:0]  chain [DIGEST_WORDS];
        logic [31:0]  blk [16];
        int unsigned  fill;
        logic [63:0]  bit_len;
        t_digest_beat digests_due [$];
        int           mismatch_cnt;

        function new();
            mismatch_cnt = 0;
            restart();
            foreach (blk[i]) blk[i] = '0;
        endfunction

        function void restart();
            foreach (chain[i]) chain[i] = SHA1_IV[i];
            fill    = 0;
            bit_len = '0;
        endfunction

        function logic [31:0] rotl(logic [31:0] v, int unsigned s);
            return (v << s) | (v >> (32 - s));
        endfunction

        // 80 rounds over the current 16-word block.
        function void compress();
            logic [31:0] w [16];
            logic [31:0] a, b, c, d, e, f, k, wr, t;
            foreach (w[i]) w[i] = blk[i];
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
            for (int r = 0; r < 80; r++) begin
                if (r < 16) begin
                    wr = w[r];
                end else begin
                    wr = rotl(w[(r - 3) & 15] ^ w[(r - 8) & 15] ^
                              w[(r - 14) & 15] ^ w[r & 15], 1);
                    w[r & 15] = wr;
                end
                if (r < 20) begin
                    f = (b & c) | (~b & d);
                    k = K_CH;
                end else if (r < 40) begin
                    f = b ^ c ^ d;
                    k = K_PAR1;
                end else if (r < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K_MAJ;
                end else begin
                    f = b ^ c ^ d;
                    k = K_PAR2;
                end
                t = rotl(a, 5) + f + e + k + wr;
                e = d;
                d = c;
                c = rotl(b, 30);
                b = a;
                a = t;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
        endfunction

        function void push_byte(logic [7:0] v);
            int unsigned idx, sh;
            idx = fill >> 2;
            sh  = (3 - (fill & 3)) * 8;
            if ((fill & 3) == 0)
                blk[idx] = 32'(v) << sh;
            else
                blk[idx] |= 32'(v) << sh;
            fill++;
            if (fill == 64) begin
                compress();
                fill = 0;
            end
        endfunction

        function void absorb_beat(logic [31:0] data, logic [2:0] nbytes, logic eom);
            int unsigned cnt;
            t_digest_beat exp_beat;
            cnt = (nbytes > 4) ? 4 : nbytes;
            for (int i = 0; i < cnt; i++)
                push_byte(data[31 - 8*i -: 8]);
            bit_len += 64'(cnt) * 8;
            if (!eom)
                return;
            push_byte(8'h80);
            while (fill != 56)
                push_byte(8'h00);
            blk[14] = bit_len[63:32];
            blk[15] = bit_len[31:0];
            compress();
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                exp_beat.word = chain[i];
                exp_beat.idx  = IDX_W'(i);
                exp_beat.last = (i == DIGEST_WORDS - 1);
                digests_due.push_back(exp_beat);
            end
            restart();
        endfunction

        function void fault(string msg);
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("[%0t] digest error: %s", $realtime, msg);
        endfunction

        function void check_digest_word(logic [31:0] word, logic [IDX_W-1:0] idx,
                                        logic last);
            t_digest_beat exp_beat;
            if (digests_due.size() == 0) begin
                fault($sformatf("unexpected word %08h idx %0d last %0b", word, idx, last));
                return;
            end
            exp_beat = digests_due.pop_front();
            if (word !== exp_beat.word || idx !== exp_beat.idx || last !== exp_beat.last)
                fault($sformatf("exp %08h/%0d/%0b got %08h/%0d/%0b",
                                exp_beat.word, exp_beat.idx, exp_beat.last,
                                word, idx, last));
        endfunction

        function int pending();
            return digests_due.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sha1md_in_if  msg_if();
    sha1md_out_if dig_if();

    sha1_message_digest_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_if),
        .o_dig   (dig_if)
    );

    sha1_digest_board board = new();

    // quiet: no idling on either side (set per message, and for the tail).
    logic quiet;
    int   beats_sent;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Digest side: ready drops in random bursts unless quiet.
    initial begin
        dig_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
                dig_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            dig_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Sample accepted digest beats; values read here are the pre-edge ones.
    always @(posedge i_clk) begin
        if (i_rst_n && dig_if.valid && dig_if.ready)
            board.check_digest_word(dig_if.digest_word, dig_if.word_index,
                                    dig_if.last_word);
    end

    // Drop valid for a burst of cycles.
    task automatic idle_gap(input int unsigned n);
        msg_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Present one message beat and hold it until the block takes it.
    task automatic send_beat(input logic [31:0] w, input logic [2:0] n, input logic eom);
        if (!quiet && $urandom_range(0, 3) == 0)
            idle_gap($urandom_range(1, 15));
        msg_if.valid          <= 1'b1;
        msg_if.data_word      <= w;
        msg_if.byte_count     <= n;
        msg_if.end_of_message <= eom;
        do @(posedge i_clk); while (msg_if.ready !== 1'b1);
        board.absorb_beat(w, n, eom);
        beats_sent++;
    endtask

    // Hold off input until every queued digest word has been delivered.
    task automatic wait_drained();
        msg_if.valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    initial begin
        int unsigned nwords;
        int unsigned pick;

        quiet                 = 1'b0;
        beats_sent            = 0;
        i_rst_n              <= 1'b0;
        msg_if.valid         <= 1'b0;
        msg_if.data_word     <= '0;
        msg_if.byte_count    <= '0;
        msg_if.end_of_message <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, "abc", an all-ones word, a single zero byte, short
        // finals, and a 56-byte message that forces a second pad block.
        send_beat(32'h0000_0000, 3'd0, 1'b1);
        send_beat(32'h6162_63FF, 3'd3, 1'b1);
        send_beat(32'hFFFF_FFFF, 3'd4, 1'b1);
        send_beat(32'h00FF_FFFF, 3'd1, 1'b1);
        send_beat(32'hA55A_C33C, 3'd2, 1'b1);
        send_beat(32'hFFFF_FFFF, 3'd4, 1'b0);
        for (int i = 1; i < 14; i++)
            send_beat($urandom, 3'd4, 1'b0);
        send_beat(32'hDEAD_BEEF, 3'd0, 1'b1);

        // Let the block go fully idle before the random run.
        wait_drained();

        // Random messages; lengths lean toward block and pad boundaries.
        while (beats_sent < BEAT_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                nwords = 0;
            else if (pick <= 2)
                nwords = $urandom_range(13, 16);
            else if (pick == 3)
                nwords = $urandom_range(28, 33);
            else
                nwords = $urandom_range(1, 24);
            quiet = (beats_sent >= BEAT_TARGET - CALM_TAIL) || ($urandom_range(0, 4) == 0);
            for (int i = 0; i < nwords; i++)
                send_beat($urandom, 3'd4, 1'b0);
            send_beat($urandom, 3'($urandom_range(0, 4)), 1'b1);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
